// ----- rtl/i2cs_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cs_pkg
// Shared types and codes of the I2C master transaction sequencer.
// ----------------------------------------------------------------------------
package i2cs_pkg;

	localparam logic [1:0] REQ_SUBMIT = 2'd0;
	localparam logic [1:0] REQ_MASTER = 2'd1;
	localparam logic [1:0] REQ_SLAVE  = 2'd2;
	localparam logic [1:0] REQ_POLL   = 2'd3;

	localparam logic [1:0] KIND_GEN  = 2'd0;
	localparam logic [1:0] KIND_RWR  = 2'd1;
	localparam logic [1:0] KIND_RRD  = 2'd2;
	localparam logic [1:0] KIND_SCAN = 2'd3;

	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_ADDR  = 3'd1;
	localparam logic [2:0] CMD_DATA  = 3'd2;
	localparam logic [2:0] CMD_STOP  = 3'd3;
	localparam logic [2:0] CMD_ACK   = 3'd4;
	localparam logic [2:0] CMD_NACK  = 3'd5;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_BERR = 2'd1;
	localparam logic [1:0] ST_ARB  = 2'd2;
	localparam logic [1:0] ST_NACK = 2'd3;

	localparam logic [2:0] PH_PEND   = 3'd0;
	localparam logic [2:0] PH_REG    = 3'd1;
	localparam logic [2:0] PH_TX     = 3'd2;
	localparam logic [2:0] PH_RSTART = 3'd3;
	localparam logic [2:0] PH_RX     = 3'd4;

	localparam int ENTRY_W = 49;

	typedef struct packed {
		logic [1:0]  kind;
		logic [6:0]  dev;
		logic [7:0]  rreg;
		logic [15:0] out_len;
		logic [15:0] in_len;
	} entry_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [7:0]  cmd_byte;
		logic [15:0] byte_index;
		logic [7:0]  rx_byte;
		logic        rx_valid;
		logic [7:0]  txn_id;
		logic        done_res;
		logic [1:0]  status;
		logic        accepted;
		logic        found;
		logic [6:0]  found_addr;
		logic        last;
	} res_t;

endpackage

// ----- rtl/i2cs_ram.sv -----
// ----------------------------------------------------------------------------
// i2cs_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module i2cs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/i2c_master_transaction_sequencer.sv -----
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer
// Queues I2C master transactions in a RAM and sequences their bus commands.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  in      | input     | req_type kind dev_addr reg_addr out_len in_len flags data_byte
//  out     | output    | cmd cmd_byte byte_index rx_byte rx_valid txn_id done_res
//          |           | status accepted found found_addr last
// An input passes through accept, a queue RAM read of the head entry and
// evaluate, then its results leave one at a time, if any. Starting a
// transaction adds a second read and evaluate of the new head. Reset clears all
// control state; the queue RAM needs none. Output stall holds the result
// register; input is not taken meanwhile.
module i2c_master_transaction_sequencer #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [1:0]  kind,
	input  logic [6:0]  dev_addr,
	input  logic [7:0]  reg_addr,
	input  logic [15:0] out_len,
	input  logic [15:0] in_len,
	input  logic        bus_err,
	input  logic        arb_lost,
	input  logic        rx_nack,
	input  logic        bus_idle,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  cmd,
	output logic [7:0]  cmd_byte,
	output logic [15:0] byte_index,
	output logic [7:0]  rx_byte,
	output logic        rx_valid,
	output logic [7:0]  txn_id,
	output logic        done_res,
	output logic [1:0]  status,
	output logic        accepted,
	output logic        found,
	output logic [6:0]  found_addr,
	output logic        last
);
	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {S_IDLE, S_READ, S_EVAL, S_OUT} state_t;

	state_t state_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic          active_q, wait_q;
	logic [2:0]    phase_q;
	logic [15:0]   out_pos_q, in_pos_q;
	logic [7:0]    scan_q, next_id_q;
	logic [1:0]    rtype_q;
	logic          berr_q, arb_q, nack_q, idle_q;
	logic [7:0]    byte_q;
	i2cs_pkg::res_t r0_q, r1_q;
	logic          r0v_q, r1v_q;
	logic          start_pend_q;

	i2cs_pkg::entry_t wentry, rentry;
	logic [AW-1:0] waddr, raddr;
	logic          we;
	i2cs_pkg::res_t sub_res;

	assign wentry = '{kind: kind, dev: dev_addr, rreg: reg_addr,
		out_len: out_len, in_len: in_len};
	assign in_stall = (state_q != S_IDLE);
	assign we = in_valid && !in_stall && req_type == i2cs_pkg::REQ_SUBMIT
		&& count_q < CW'(QUEUE_DEPTH);

	always_comb begin
		logic [AW:0] t;
		t = {1'b0, head_q} + {1'b0, count_q[AW-1:0]};
		if (t >= (AW+1)'(QUEUE_DEPTH)) begin
			t = t - (AW+1)'(QUEUE_DEPTH);
		end
		waddr = t[AW-1:0];
	end

	assign raddr = head_q;

	always_comb begin
		sub_res = '0;
		sub_res.accepted = we;
		sub_res.txn_id = we ? next_id_q : 8'd0;
		sub_res.last = 1'b1;
	end

	i2cs_ram #(.WIDTH(i2cs_pkg::ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wentry),
		.raddr(raddr), .rdata(rentry)
	);

	// evaluation of one input with the head entry
	i2cs_pkg::res_t e0;
	logic e2;
	logic [AW-1:0] nhead;
	logic [CW-1:0] ncount;
	logic nactive, nwait, need_start;
	logic [2:0] nphase;
	logic [15:0] nout, nin;
	logic [7:0] nscan, hid;

	always_comb begin
		logic fin;
		logic [1:0] st;
		logic [8:0] sa;
		i2cs_pkg::res_t r;
		r = '0;
		e0 = '0;
		e2 = 1'b0;
		fin = 1'b0;
		st = i2cs_pkg::ST_OK;
		nhead = head_q;
		ncount = count_q;
		nactive = active_q;
		nwait = wait_q;
		nphase = phase_q;
		nout = out_pos_q;
		nin = in_pos_q;
		nscan = scan_q;
		hid = next_id_q - 8'(count_q);
		need_start = 1'b0;
		sa = {1'b0, scan_q} + 9'd1;
		r.txn_id = hid;
		if (rtype_q == i2cs_pkg::REQ_MASTER && active_q) begin
			e2 = 1'b1;
			if (berr_q) begin
				fin = 1'b1; st = i2cs_pkg::ST_BERR;
			end else if (arb_q) begin
				fin = 1'b1; st = i2cs_pkg::ST_ARB;
			end else if (rentry.kind == i2cs_pkg::KIND_SCAN) begin
				if (!nack_q) begin
					r.found = 1'b1;
					r.found_addr = scan_q[6:0];
				end
				nscan = sa[7:0];
				if (sa[7:0] <= 8'd127) begin
					r.cmd = i2cs_pkg::CMD_ADDR;
					r.cmd_byte = {sa[6:0], 1'b0};
				end else begin
					r.cmd = i2cs_pkg::CMD_STOP;
					fin = 1'b1;
				end
			end else if (nack_q) begin
				r.cmd = i2cs_pkg::CMD_STOP; fin = 1'b1; st = i2cs_pkg::ST_NACK;
			end else if (phase_q == i2cs_pkg::PH_TX) begin
				if (out_pos_q >= rentry.out_len) begin
					if (rentry.kind == i2cs_pkg::KIND_GEN && rentry.in_len != 16'd0) begin
						r.cmd = i2cs_pkg::CMD_ADDR;
						r.cmd_byte = {rentry.dev, 1'b1};
						nphase = i2cs_pkg::PH_RX;
					end else begin
						r.cmd = i2cs_pkg::CMD_STOP; fin = 1'b1;
					end
				end else begin
					r.cmd = i2cs_pkg::CMD_DATA;
					r.cmd_byte = byte_q;
					r.byte_index = out_pos_q;
					nout = out_pos_q + 16'd1;
				end
			end else if (phase_q == i2cs_pkg::PH_REG) begin
				r.cmd = i2cs_pkg::CMD_DATA;
				r.cmd_byte = rentry.rreg;
				nphase = (rentry.kind == i2cs_pkg::KIND_RWR) ? i2cs_pkg::PH_TX
					: i2cs_pkg::PH_RSTART;
			end else if (phase_q == i2cs_pkg::PH_RSTART) begin
				if (rentry.in_len != 16'd0) begin
					r.cmd = i2cs_pkg::CMD_ADDR;
					r.cmd_byte = {rentry.dev, 1'b1};
					nphase = i2cs_pkg::PH_RX;
				end else begin
					r.cmd = i2cs_pkg::CMD_STOP; fin = 1'b1;
				end
			end else begin
				e2 = 1'b0;
			end
		end else if (rtype_q == i2cs_pkg::REQ_SLAVE && active_q
				&& phase_q == i2cs_pkg::PH_RX) begin
			e2 = 1'b1;
			r.byte_index = in_pos_q;
			r.rx_byte = byte_q;
			r.rx_valid = 1'b1;
			if ({1'b0, in_pos_q} + 17'd1 >= {1'b0, rentry.in_len}) begin
				r.cmd = i2cs_pkg::CMD_NACK; fin = 1'b1;
			end else begin
				r.cmd = i2cs_pkg::CMD_ACK;
				nin = in_pos_q + 16'd1;
			end
		end
		if (fin) begin
			r.done_res = 1'b1;
			r.status = st;
			if (count_q != '0) begin
				nhead = (32'(head_q) + 1 >= QUEUE_DEPTH) ? '0 : head_q + AW'(1);
				ncount = count_q - CW'(1);
			end
			nactive = 1'b0;
			nphase = i2cs_pkg::PH_PEND;
		end
		// start decision
		if (!nactive) begin
			if (nwait && idle_q) begin
				nwait = 1'b0;
			end
			if (!nwait && ncount != '0) begin
				if (idle_q) begin
					need_start = 1'b1;
				end else begin
					nwait = 1'b1;
				end
			end else if (nwait && !idle_q) begin
				nwait = 1'b1;
			end
		end
		r.last = !need_start;
		e0 = r;
	end

	// start result from the new head entry
	i2cs_pkg::res_t sres;
	logic [2:0] sphase;
	always_comb begin
		logic rd;
		sres = '0;
		sres.cmd = i2cs_pkg::CMD_ADDR;
		sres.txn_id = next_id_q - 8'(count_q);
		sres.last = 1'b1;
		rd = rentry.out_len == 16'd0 && rentry.in_len != 16'd0;
		if (rentry.kind == i2cs_pkg::KIND_GEN) begin
			sphase = rd ? i2cs_pkg::PH_RX : i2cs_pkg::PH_TX;
			sres.cmd_byte = {rentry.dev, rd};
		end else if (rentry.kind == i2cs_pkg::KIND_SCAN) begin
			sphase = i2cs_pkg::PH_TX;
			sres.cmd_byte = 8'd2;
		end else begin
			sphase = i2cs_pkg::PH_REG;
			sres.cmd_byte = {rentry.dev, 1'b0};
		end
	end

	i2cs_pkg::res_t cur;
	assign cur = r0v_q ? r0_q : r1_q;
	assign cmd = cur.cmd;
	assign cmd_byte = cur.cmd_byte;
	assign byte_index = cur.byte_index;
	assign rx_byte = cur.rx_byte;
	assign rx_valid = cur.rx_valid;
	assign txn_id = cur.txn_id;
	assign done_res = cur.done_res;
	assign status = cur.status;
	assign accepted = cur.accepted;
	assign found = cur.found;
	assign found_addr = cur.found_addr;
	assign last = cur.last;

	assign out_valid = (state_q == S_OUT) && (r0v_q || r1v_q) && !start_pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			count_q <= '0;
			active_q <= 1'b0;
			wait_q <= 1'b0;
			phase_q <= i2cs_pkg::PH_PEND;
			out_pos_q <= '0;
			in_pos_q <= '0;
			scan_q <= '0;
			next_id_q <= '0;
			r0v_q <= 1'b0;
			r1v_q <= 1'b0;
			start_pend_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						rtype_q <= req_type;
						berr_q <= bus_err;
						arb_q <= arb_lost;
						nack_q <= rx_nack;
						idle_q <= bus_idle;
						byte_q <= data_byte;
						r0_q <= sub_res;
						r0v_q <= (req_type == i2cs_pkg::REQ_SUBMIT);
						r1v_q <= 1'b0;
						if (we) begin
							next_id_q <= next_id_q + 8'd1;
							count_q <= count_q + CW'(1);
						end
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (start_pend_q) begin
						// head re-read done: issue the start command
						start_pend_q <= 1'b0;
						active_q <= 1'b1;
						out_pos_q <= '0;
						in_pos_q <= '0;
						phase_q <= sphase;
						if (rentry.kind == i2cs_pkg::KIND_SCAN) begin
							scan_q <= 8'd1;
						end
						if (r0v_q) begin
							r1_q <= sres;
							r1v_q <= 1'b1;
						end else begin
							r0_q <= sres;
							r0v_q <= 1'b1;
						end
						state_q <= S_OUT;
					end else begin
						if (e2) begin
							r0_q <= e0;
							r0v_q <= 1'b1;
						end else if (need_start) begin
							r0_q.last <= 1'b0;
						end
						head_q <= nhead;
						count_q <= ncount;
						active_q <= nactive;
						wait_q <= nwait;
						phase_q <= nphase;
						out_pos_q <= nout;
						in_pos_q <= nin;
						scan_q <= nscan;
						if (need_start) begin
							start_pend_q <= 1'b1;
							state_q <= S_READ;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					if (!r0v_q && !r1v_q) begin
						state_q <= S_IDLE;
					end else if (!out_stall) begin
						if (r0v_q && r1v_q) begin
							r0v_q <= 1'b0;
						end else begin
							r0v_q <= 1'b0;
							r1v_q <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- tb/tb_i2c_master_transaction_sequencer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_i2c_master_transaction_sequencer
// Runs submits and bus events through the I2C master transaction sequencer
// and checks every result field against an in-bench model of the command
// sequencing. Directed cases come first, then random transaction scripts
// mixed with noise, queue-full bursts and random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_i2c_master_transaction_sequencer;

	localparam int DEPTH = 8;
	localparam int WDOG_LIMIT = 4000;

	typedef struct {
		logic [1:0]  rt;
		logic [1:0]  kd;
		logic [6:0]  dev;
		logic [7:0]  rg;
		logic [15:0] ol;
		logic [15:0] il;
		logic        be;
		logic        al;
		logic        nk;
		logic        idle;
		logic [7:0]  db;
	} bus_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] req_type = '0;
	logic [1:0] kind = '0;
	logic [6:0] dev_addr = '0;
	logic [7:0] reg_addr = '0;
	logic [15:0] out_len = '0;
	logic [15:0] in_len = '0;
	logic bus_err = 1'b0;
	logic arb_lost = 1'b0;
	logic rx_nack = 1'b0;
	logic bus_idle = 1'b0;
	logic [7:0] data_byte = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] cmd;
	logic [7:0] cmd_byte;
	logic [15:0] byte_index;
	logic [7:0] rx_byte;
	logic rx_valid;
	logic [7:0] txn_id;
	logic done_res;
	logic [1:0] status;
	logic accepted;
	logic found;
	logic [6:0] found_addr;
	logic last;

	always #5 clk = ~clk;

	i2c_master_transaction_sequencer #(.QUEUE_DEPTH(DEPTH)) u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .kind(kind), .dev_addr(dev_addr), .reg_addr(reg_addr),
		.out_len(out_len), .in_len(in_len), .bus_err(bus_err), .arb_lost(arb_lost),
		.rx_nack(rx_nack), .bus_idle(bus_idle), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .cmd_byte(cmd_byte),
		.byte_index(byte_index), .rx_byte(rx_byte), .rx_valid(rx_valid),
		.txn_id(txn_id), .done_res(done_res), .status(status),
		.accepted(accepted), .found(found), .found_addr(found_addr),
		.last(last)
	);

	bus_item_t pending_q[$];
	i2cs_pkg::res_t expected_q[$];
	int n_errors = 0;
	int n_in = 0;
	int n_out = 0;
	int n_done = 0;
	int n_found = 0;
	int n_gen = 0;
	bit quiet = 1'b0;

	// sequencer model state
	i2cs_pkg::entry_t q_mem[DEPTH];
	int q_head = 0;
	int q_count = 0;
	bit m_active = 1'b0;
	bit m_wait_idle = 1'b0;
	logic [2:0] m_phase = i2cs_pkg::PH_PEND;
	logic [15:0] m_out_pos = '0;
	logic [15:0] m_in_pos = '0;
	logic [7:0] m_scan_addr = '0;
	logic [7:0] m_next_id = '0;
	i2cs_pkg::res_t rbuf[2];
	int rn;

	function automatic int alloc_res();
		if (rn >= 2)
			rn = 1;
		rbuf[rn] = '0;
		rn++;
		return rn - 1;
	endfunction

	function automatic logic [7:0] head_id();
		return m_next_id - 8'(q_count);
	endfunction

	function automatic void end_txn(int i, logic [1:0] st);
		rbuf[i].txn_id = head_id();
		rbuf[i].done_res = 1'b1;
		rbuf[i].status = st;
		if (q_count > 0) begin
			q_head = (q_head + 1 >= DEPTH) ? 0 : q_head + 1;
			q_count--;
		end
		m_active = 1'b0;
		m_phase = i2cs_pkg::PH_PEND;
	endfunction

	function automatic void try_start(logic idle);
		i2cs_pkg::entry_t e;
		int i;
		bit rd;
		if (m_active)
			return;
		if (m_wait_idle) begin
			if (!idle)
				return;
			m_wait_idle = 1'b0;
		end
		if (q_count == 0)
			return;
		if (!idle) begin
			m_wait_idle = 1'b1;
			return;
		end
		e = q_mem[q_head];
		m_active = 1'b1;
		m_out_pos = '0;
		m_in_pos = '0;
		i = alloc_res();
		rbuf[i].cmd = i2cs_pkg::CMD_ADDR;
		rbuf[i].txn_id = head_id();
		if (e.kind == i2cs_pkg::KIND_GEN) begin
			rd = (e.out_len == 0) && (e.in_len != 0);
			m_phase = rd ? i2cs_pkg::PH_RX : i2cs_pkg::PH_TX;
			rbuf[i].cmd_byte = {e.dev, rd};
		end else if (e.kind == i2cs_pkg::KIND_SCAN) begin
			m_phase = i2cs_pkg::PH_TX;
			m_scan_addr = 8'd1;
			rbuf[i].cmd_byte = 8'd2;
		end else begin
			m_phase = i2cs_pkg::PH_REG;
			rbuf[i].cmd_byte = {e.dev, 1'b0};
		end
	endfunction

	function automatic void master_event(bus_item_t it);
		i2cs_pkg::entry_t e;
		int i;
		e = q_mem[q_head];
		if (it.be) begin
			end_txn(alloc_res(), i2cs_pkg::ST_BERR);
			return;
		end
		if (it.al) begin
			end_txn(alloc_res(), i2cs_pkg::ST_ARB);
			return;
		end
		if (e.kind == i2cs_pkg::KIND_SCAN) begin
			i = alloc_res();
			rbuf[i].txn_id = head_id();
			if (!it.nk) begin
				rbuf[i].found = 1'b1;
				rbuf[i].found_addr = m_scan_addr[6:0];
			end
			m_scan_addr = m_scan_addr + 8'd1;
			if (m_scan_addr <= 8'd127) begin
				rbuf[i].cmd = i2cs_pkg::CMD_ADDR;
				rbuf[i].cmd_byte = {m_scan_addr[6:0], 1'b0};
			end else begin
				rbuf[i].cmd = i2cs_pkg::CMD_STOP;
				end_txn(i, i2cs_pkg::ST_OK);
			end
			return;
		end
		if (it.nk) begin
			i = alloc_res();
			rbuf[i].cmd = i2cs_pkg::CMD_STOP;
			end_txn(i, i2cs_pkg::ST_NACK);
			return;
		end
		if (m_phase == i2cs_pkg::PH_TX) begin
			i = alloc_res();
			rbuf[i].txn_id = head_id();
			if (m_out_pos >= e.out_len) begin
				if (e.kind == i2cs_pkg::KIND_GEN && e.in_len != 0) begin
					rbuf[i].cmd = i2cs_pkg::CMD_ADDR;
					rbuf[i].cmd_byte = {e.dev, 1'b1};
					m_phase = i2cs_pkg::PH_RX;
				end else begin
					rbuf[i].cmd = i2cs_pkg::CMD_STOP;
					end_txn(i, i2cs_pkg::ST_OK);
				end
			end else begin
				rbuf[i].cmd = i2cs_pkg::CMD_DATA;
				rbuf[i].cmd_byte = it.db;
				rbuf[i].byte_index = m_out_pos;
				m_out_pos = m_out_pos + 16'd1;
			end
		end else if (m_phase == i2cs_pkg::PH_REG) begin
			i = alloc_res();
			rbuf[i].txn_id = head_id();
			rbuf[i].cmd = i2cs_pkg::CMD_DATA;
			rbuf[i].cmd_byte = e.rreg;
			m_phase = (e.kind == i2cs_pkg::KIND_RWR) ? i2cs_pkg::PH_TX
				: i2cs_pkg::PH_RSTART;
		end else if (m_phase == i2cs_pkg::PH_RSTART) begin
			i = alloc_res();
			rbuf[i].txn_id = head_id();
			if (e.in_len != 0) begin
				rbuf[i].cmd = i2cs_pkg::CMD_ADDR;
				rbuf[i].cmd_byte = {e.dev, 1'b1};
				m_phase = i2cs_pkg::PH_RX;
			end else begin
				rbuf[i].cmd = i2cs_pkg::CMD_STOP;
				end_txn(i, i2cs_pkg::ST_OK);
			end
		end
	endfunction

	function automatic void slave_event(bus_item_t it);
		int i;
		i = alloc_res();
		rbuf[i].txn_id = head_id();
		rbuf[i].byte_index = m_in_pos;
		rbuf[i].rx_byte = it.db;
		rbuf[i].rx_valid = 1'b1;
		if (32'(m_in_pos) + 1 >= 32'(q_mem[q_head].in_len)) begin
			rbuf[i].cmd = i2cs_pkg::CMD_NACK;
			end_txn(i, i2cs_pkg::ST_OK);
		end else begin
			rbuf[i].cmd = i2cs_pkg::CMD_ACK;
			m_in_pos = m_in_pos + 16'd1;
		end
	endfunction

	function automatic void predict_transfer(bus_item_t it);
		int i;
		int t;
		rn = 0;
		if (it.rt == i2cs_pkg::REQ_SUBMIT) begin
			i = alloc_res();
			if (q_count < DEPTH) begin
				t = q_head + q_count;
				if (t >= DEPTH)
					t -= DEPTH;
				q_mem[t] = '{kind: it.kd, dev: it.dev, rreg: it.rg,
					out_len: it.ol, in_len: it.il};
				rbuf[i].accepted = 1'b1;
				rbuf[i].txn_id = m_next_id;
				m_next_id = m_next_id + 8'd1;
				q_count++;
			end
		end else if (it.rt == i2cs_pkg::REQ_MASTER) begin
			if (m_active)
				master_event(it);
		end else if (it.rt == i2cs_pkg::REQ_SLAVE) begin
			if (m_active && m_phase == i2cs_pkg::PH_RX)
				slave_event(it);
		end
		try_start(it.idle);
		if (rn > 0)
			rbuf[rn - 1].last = 1'b1;
		for (i = 0; i < rn; i++)
			expected_q.push_back(rbuf[i]);
	endfunction

	task automatic report(string what, int got, int want);
		$display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
		n_errors++;
	endtask

	task automatic check_result(i2cs_pkg::res_t got);
		i2cs_pkg::res_t w;
		if (expected_q.size() == 0) begin
			report("unexpected result, cmd", got.cmd, -1);
			return;
		end
		w = expected_q.pop_front();
		if (got.cmd !== w.cmd) report("cmd", got.cmd, w.cmd);
		if (got.cmd_byte !== w.cmd_byte) report("cmd_byte", got.cmd_byte, w.cmd_byte);
		if (got.byte_index !== w.byte_index)
			report("byte_index", got.byte_index, w.byte_index);
		if (got.rx_byte !== w.rx_byte) report("rx_byte", got.rx_byte, w.rx_byte);
		if (got.rx_valid !== w.rx_valid) report("rx_valid", got.rx_valid, w.rx_valid);
		if (got.txn_id !== w.txn_id) report("txn_id", got.txn_id, w.txn_id);
		if (got.done_res !== w.done_res) report("done_res", got.done_res, w.done_res);
		if (got.status !== w.status) report("status", got.status, w.status);
		if (got.accepted !== w.accepted) report("accepted", got.accepted, w.accepted);
		if (got.found !== w.found) report("found", got.found, w.found);
		if (got.found_addr !== w.found_addr)
			report("found_addr", got.found_addr, w.found_addr);
		if (got.last !== w.last) report("last", got.last, w.last);
		if (w.done_res) n_done++;
		if (w.found) n_found++;
	endtask

	// monitor and watchdog
	bit in_took = 1'b0;
	int idle_cycles = 0;
	bus_item_t pending_head;

	always @(posedge clk) begin
		in_took = arst_n && in_valid && !in_stall;
		if (arst_n) begin
			if (in_took) begin
				predict_transfer(pending_head);
				n_in++;
			end
			if (out_valid && !out_stall) begin
				check_result('{cmd, cmd_byte, byte_index, rx_byte, rx_valid, txn_id,
					done_res, status, accepted, found, found_addr, last});
				n_out++;
			end
			if (in_took || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", WDOG_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// driver
	int in_gap = 0;
	int stall_left = 0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 65)
			return 0;
		if (r < 96)
			return $urandom_range(1, 3);
		return $urandom_range(15, 60);
	endfunction

	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_took) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					pending_head = pending_q.pop_front();
					req_type <= pending_head.rt;
					kind <= pending_head.kd;
					dev_addr <= pending_head.dev;
					reg_addr <= pending_head.rg;
					out_len <= pending_head.ol;
					in_len <= pending_head.il;
					bus_err <= pending_head.be;
					arb_lost <= pending_head.al;
					rx_nack <= pending_head.nk;
					bus_idle <= pending_head.idle;
					data_byte <= pending_head.db;
					in_valid <= 1'b1;
					in_gap = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (quiet || $urandom_range(0, 99) < 70) begin
				out_stall <= 1'b0;
			end else begin
				stall_left = ($urandom_range(0, 99) < 95) ? $urandom_range(0, 2)
					: $urandom_range(15, 60);
				out_stall <= 1'b1;
			end
		end
	end

	// stimulus
	function automatic bus_item_t bus_event(logic [1:0] rt);
		bus_item_t it;
		it.rt = rt;
		it.kd = 2'($urandom());
		it.dev = 7'($urandom());
		it.rg = 8'($urandom());
		it.ol = 16'($urandom());
		it.il = 16'($urandom());
		it.be = 1'b0;
		it.al = 1'b0;
		it.nk = ($urandom_range(0, 99) < 2);
		it.idle = ($urandom_range(0, 99) < 95);
		it.db = 8'($urandom());
		return it;
	endfunction

	function automatic bus_item_t submit(logic [1:0] kd, logic [6:0] dev, logic [7:0] rg,
			logic [15:0] ol, logic [15:0] il, logic idle);
		bus_item_t it;
		it = bus_event(i2cs_pkg::REQ_SUBMIT);
		it.kd = kd;
		it.dev = dev;
		it.rg = rg;
		it.ol = ol;
		it.il = il;
		it.idle = idle;
		return it;
	endfunction

	task automatic push(bus_item_t it);
		pending_q.push_back(it);
		n_gen++;
	endtask

	task automatic push_master(logic be, logic al, logic nk, logic idle);
		bus_item_t it;
		it = bus_event(i2cs_pkg::REQ_MASTER);
		it.be = be;
		it.al = al;
		it.nk = nk;
		it.idle = idle;
		push(it);
	endtask

	// emit the events that carry one transaction to its end, with rare faults
	task automatic run_script(logic [1:0] kd, logic [15:0] ol, logic [15:0] il, bit big);
		int n_m;
		int n_s;
		int j;
		int r;
		bus_item_t it;
		case (kd)
			i2cs_pkg::KIND_GEN: begin
				n_m = (ol == 0 && il != 0) ? 0 : ol + 1;
				n_s = il;
			end
			i2cs_pkg::KIND_RWR: begin
				n_m = ol + 2;
				n_s = 0;
			end
			i2cs_pkg::KIND_RRD: begin
				n_m = 2;
				n_s = il;
			end
			default: begin
				n_m = 127;
				n_s = 0;
			end
		endcase
		for (j = 0; j < n_m + n_s; j++) begin
			if (big && j >= 5) begin
				push_master($urandom_range(0, 1), $urandom_range(0, 1), 1'b0, 1'b1);
				return;
			end
			r = $urandom_range(0, 199);
			if (j < n_m) begin
				it = bus_event(i2cs_pkg::REQ_MASTER);
				if (kd != i2cs_pkg::KIND_SCAN)
					it.nk = (r < 3);
				else
					it.nk = ($urandom_range(0, 99) < 85);
				it.be = (r >= 197);
				it.al = (r >= 195 && r < 197) || (r == 199);
			end else begin
				it = bus_event(i2cs_pkg::REQ_SLAVE);
			end
			if ($urandom_range(0, 99) < 4)
				push(bus_event(2'($urandom())));
			push(it);
			if (it.be || it.al || (it.nk && kd != i2cs_pkg::KIND_SCAN))
				return;
		end
	endtask

	task automatic random_txn();
		logic [1:0] kd;
		logic [15:0] ol;
		logic [15:0] il;
		bit big;
		int r;
		r = $urandom_range(0, 999);
		kd = (r < 8) ? i2cs_pkg::KIND_SCAN : 2'($urandom_range(0, 2));
		big = ($urandom_range(0, 99) < 6);
		if (big) begin
			ol = 16'($urandom());
			il = 16'($urandom());
		end else if ($urandom_range(0, 99) < 90) begin
			ol = 16'($urandom_range(0, 4));
			il = 16'($urandom_range(0, 4));
		end else begin
			ol = 16'($urandom_range(0, 24));
			il = 16'($urandom_range(0, 24));
		end
		push(submit(kd, 7'($urandom()), 8'($urandom()), ol, il,
			$urandom_range(0, 99) < 92));
		run_script(kd, ol, il, big);
	endtask

	task automatic burst_full();
		int j;
		for (j = 0; j < DEPTH + 2; j++)
			push(submit(i2cs_pkg::KIND_GEN, 7'($urandom()), 8'($urandom()),
				16'd0, 16'd0, 1'b0));
		for (j = 0; j < DEPTH + 2; j++)
			push_master(1'b0, 1'b0, 1'b0, 1'b1);
	endtask

	task automatic drain();
		while (pending_q.size() > 0 || expected_q.size() > 0 || in_valid)
			@(posedge clk);
	endtask

	initial begin
		int j;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: idle events, zero-length generic, register read with no data,
		// register write, nack, faults, waiting for a busy bus, read-only generic
		push(bus_event(i2cs_pkg::REQ_MASTER));
		push(bus_event(i2cs_pkg::REQ_SLAVE));
		push(submit(i2cs_pkg::KIND_GEN, 7'h7F, 8'hFF, 16'd0, 16'd0, 1'b1));
		push_master(1'b0, 1'b0, 1'b0, 1'b1);
		push(submit(i2cs_pkg::KIND_RRD, 7'h00, 8'hFF, 16'hFFFF, 16'd0, 1'b1));
		push(bus_event(i2cs_pkg::REQ_SLAVE));
		push_master(1'b0, 1'b0, 1'b0, 1'b1);
		push_master(1'b0, 1'b0, 1'b0, 1'b1);
		push(submit(i2cs_pkg::KIND_RWR, 7'h55, 8'hA5, 16'd1, 16'hFFFF, 1'b1));
		push_master(1'b0, 1'b0, 1'b0, 1'b1);
		push_master(1'b0, 1'b0, 1'b1, 1'b1);
		push(submit(i2cs_pkg::KIND_SCAN, 7'h2A, 8'h00, 16'd0, 16'd0, 1'b0));
		push(bus_event(i2cs_pkg::REQ_POLL));
		pending_q[$].idle = 1'b0;
		push(bus_event(i2cs_pkg::REQ_POLL));
		pending_q[$].idle = 1'b1;
		push_master(1'b0, 1'b0, 1'b1, 1'b1);
		push_master(1'b1, 1'b1, 1'b0, 1'b1);
		push(submit(i2cs_pkg::KIND_GEN, 7'h11, 8'h00, 16'd0, 16'd2, 1'b1));
		push_master(1'b0, 1'b0, 1'b0, 1'b1);
		push(bus_event(i2cs_pkg::REQ_SLAVE));
		push(bus_event(i2cs_pkg::REQ_SLAVE));
		push(submit(i2cs_pkg::KIND_GEN, 7'h22, 8'h00, 16'd1, 16'd0, 1'b1));
		push_master(1'b0, 1'b1, 1'b0, 1'b1);
		drain();

		// one full scan with scattered hits
		push(submit(i2cs_pkg::KIND_SCAN, 7'($urandom()), 8'($urandom()),
			16'd0, 16'd0, 1'b1));
		run_script(i2cs_pkg::KIND_SCAN, 16'd0, 16'd0, 1'b0);

		for (j = 0; n_gen < 1600; j++) begin
			if (j % 60 == 59)
				quiet = !quiet;
			if (j == 150) begin
				// hold off until every expected result is back
				drain();
			end
			if ($urandom_range(0, 99) < 3)
				burst_full();
			else if ($urandom_range(0, 99) < 8)
				push(bus_event(2'($urandom())));
			else
				random_txn();
			while (pending_q.size() > 40)
				@(posedge clk);
		end
		drain();
		repeat (30) @(posedge clk);
		$display("%0d input transfers and %0d results checked", n_in, n_out);
		$display("%0d transactions completed, %0d scan hits", n_done, n_found);
		if (n_errors == 0 && expected_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
